// ===== design/rws_pkg.sv =====
// ----------------------------------------------------------------------------
// rws_pkg: shared constants and types for the rolling window statistics block
// Field widths, window geometry, arithmetic unit widths and the sequencer
// state type.
// ----------------------------------------------------------------------------
package rws_pkg;

    localparam int WINDOW = 16;
    localparam int POS_W = $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW + 1);

    localparam int TEMP_W = 16;
    localparam int HUM_W = 16;
    localparam int TIME_W = 32;
    localparam int VAR_W = 32;
    localparam int RATE_W = 24;
    localparam int EDGE_W = 5;

    localparam int SUM_W = TEMP_W + POS_W;
    localparam int SQ_W = 2 * TEMP_W - 1 + POS_W;
    localparam int NUM_W = SQ_W + CNT_W;
    localparam int DEN_W = 2 * CNT_W;

    localparam int MUL_A_W = SQ_W;
    localparam int MUL_B_W = SUM_W;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

    localparam int DIV_N_W = NUM_W;
    localparam int DIV_D_W = TIME_W;
    localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

    localparam int MS_PER_S_Q8 = 256000;
    localparam int RATE_NUM_W = EDGE_W + 18;

    localparam logic [EDGE_W-1:0] EDGE_MAX = '1;
    localparam logic [RATE_W-1:0] RATE_MAX = '1;
    localparam logic [VAR_W-1:0] VAR_MAX = '1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SQ_START,
        ST_SQ_WAIT,
        ST_PROD_START,
        ST_PROD_WAIT,
        ST_VAR_START,
        ST_VAR_WAIT,
        ST_FINISH
    } state_t;

endpackage

// ===== design/rws_sample_if.sv =====
// ----------------------------------------------------------------------------
// rws_sample_if: sensor reading channel
// Valid/ready handshake carrying one sensor reading per word.
// ----------------------------------------------------------------------------
interface rws_sample_if;
    import rws_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] temperature;
    logic [HUM_W-1:0]         humidity;
    logic                     motion;
    logic                     door_state;
    logic [TIME_W-1:0]        time_ms;

    modport source (
        output valid,
        output temperature,
        output humidity,
        output motion,
        output door_state,
        output time_ms,
        input  ready
    );

    modport sink (
        input  valid,
        input  temperature,
        input  humidity,
        input  motion,
        input  door_state,
        input  time_ms,
        output ready
    );

endinterface

// ===== design/rws_result_if.sv =====
// ----------------------------------------------------------------------------
// rws_result_if: statistics result channel
// Valid/ready handshake carrying the echoed reading and window statistics.
// ----------------------------------------------------------------------------
interface rws_result_if;
    import rws_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] temp_out;
    logic [HUM_W-1:0]         humidity_out;
    logic                     motion_out;
    logic                     door_out;
    logic signed [TEMP_W-1:0] temp_mean;
    logic [VAR_W-1:0]         temp_var;
    logic [RATE_W-1:0]        motion_rate;
    logic [TIME_W-1:0]        time_out;

    modport source (
        output valid,
        output temp_out,
        output humidity_out,
        output motion_out,
        output door_out,
        output temp_mean,
        output temp_var,
        output motion_rate,
        output time_out,
        input  ready
    );

    modport sink (
        input  valid,
        input  temp_out,
        input  humidity_out,
        input  motion_out,
        input  door_out,
        input  temp_mean,
        input  temp_var,
        input  motion_rate,
        input  time_out,
        output ready
    );

endinterface

// ===== design/rolling_window_stats.sv =====
// ----------------------------------------------------------------------------
// rolling_window_stats: sliding window temperature mean/variance and
// motion event rate
// Each reading is echoed together with the mean and sample variance of the
// last WINDOW temperatures and the rate of rising motion edges per second (Q16.8).
// ----------------------------------------------------------------------------
// The block works on one reading at a time. Each reading makes two passes
// through a pair of shift-add multipliers (squares, then the variance
// numerator terms) followed by a restoring divider that produces the variance
// one quotient bit per cycle from a numerator of NUM_W = 31 + log2 WINDOW +
// log2(WINDOW + 1) bits. The mean and rate divisions run alongside on their
// own dividers. The input is ready again in the cycle after the result has
// been placed in the output register, even while that result waits to be
// taken; a result still waiting when the next one is done holds the block
// until it is taken.
// The temperature ring lives in a small RAM; entries not yet written read as
// zero through the fill count, so no clearing pass is needed after reset.
module rolling_window_stats (
    input logic          clk,
    input logic          rst_n,
    rws_sample_if.sink   sample,
    rws_result_if.source result
);
    import rws_pkg::*;

    state_t state_reg;
    state_t state_next;

    logic in_ready;
    logic load_item;
    logic sq_start;
    logic prod_start;
    logic var_start;
    logic out_load;
    logic out_free;
    logic accept;

    logic [POS_W-1:0]         pos_reg;
    logic [POS_W-1:0]         pos_next;
    logic [CNT_W-1:0]         fill_reg;
    logic [CNT_W-1:0]         fill_next;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;
    logic [SQ_W-1:0]          sumsq_reg;
    logic [SQ_W-1:0]          sumsq_next;
    logic [EDGE_W-1:0]        edge_cnt_reg;
    logic [EDGE_W-1:0]        edge_hit;
    logic                     edge_inc;
    logic                     last_motion_reg;
    logic [TIME_W-1:0]        window_start_reg;
    logic                     wrap;

    logic signed [TEMP_W-1:0] temp_reg;
    logic [HUM_W-1:0]         hum_reg;
    logic                     motion_reg;
    logic                     door_reg;
    logic [TIME_W-1:0]        time_reg;
    logic [POS_W-1:0]         item_pos_reg;
    logic                     old_valid_reg;
    logic signed [TEMP_W-1:0] old_reg;
    logic signed [TEMP_W-1:0] old_val;
    logic [TIME_W-1:0]        elapsed_reg;
    logic [RATE_NUM_W-1:0]    rate_num_reg;
    logic [NUM_W-1:0]         num_reg;
    logic [NUM_W-1:0]         num_next;
    logic [NUM_W-1:0]         n_sumsq;
    logic [NUM_W-1:0]         sum_sq;
    logic [DEN_W-1:0]         den;

    logic [TEMP_W-1:0]        ram_rdata;
    logic [TEMP_W-1:0]        t_mag;
    logic [TEMP_W-1:0]        o_mag;
    logic [SUM_W-1:0]         s1_mag;

    logic                     mul_start;
    logic [MUL_A_W-1:0]       mul0_a;
    logic [MUL_B_W-1:0]       mul0_b;
    logic [MUL_A_W-1:0]       mul1_a;
    logic [MUL_B_W-1:0]       mul1_b;
    logic [MUL_P_W-1:0]       mul0_p;
    logic [MUL_P_W-1:0]       mul1_p;
    logic                     mul0_busy;
    logic                     mul1_busy;
    logic                     mul_busy;

    logic [DIV_N_W-1:0]       mean_q;
    logic [DIV_N_W-1:0]       rate_q;
    logic [DIV_N_W-1:0]       var_q;
    logic                     mean_busy;
    logic                     rate_busy;
    logic                     var_busy;

    logic [TEMP_W-1:0]        mean_mag;
    logic [TEMP_W-1:0]        mean_val;
    logic [VAR_W-1:0]         var_val;
    logic [RATE_W-1:0]        rate_val;

    logic                     out_valid_reg;
    logic signed [TEMP_W-1:0] temp_out_reg;
    logic [HUM_W-1:0]         hum_out_reg;
    logic                     motion_out_reg;
    logic                     door_out_reg;
    logic [TEMP_W-1:0]        mean_out_reg;
    logic [VAR_W-1:0]         var_out_reg;
    logic [RATE_W-1:0]        rate_out_reg;
    logic [TIME_W-1:0]        time_out_reg;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign accept   = sample.valid && in_ready;
    assign out_free = !out_valid_reg || result.ready;
    assign mul_busy = mul0_busy || mul1_busy;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:       state_next = ST_SQ_START;
            ST_SQ_START:   state_next = ST_SQ_WAIT;
            ST_SQ_WAIT:
            begin
                if (!mul_busy)
                begin
                    state_next = ST_PROD_START;
                end
            end
            ST_PROD_START: state_next = ST_PROD_WAIT;
            ST_PROD_WAIT:
            begin
                if (!mul_busy)
                begin
                    state_next = ST_VAR_START;
                end
            end
            ST_VAR_START:  state_next = ST_VAR_WAIT;
            ST_VAR_WAIT:
            begin
                if (!var_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        load_item  = 1'b0;
        sq_start   = 1'b0;
        prod_start = 1'b0;
        var_start  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:       in_ready   = 1'b1;
            ST_LOAD:       load_item  = 1'b1;
            ST_SQ_START:   sq_start   = 1'b1;
            ST_PROD_START: prod_start = 1'b1;
            ST_VAR_START:  var_start  = 1'b1;
            ST_FINISH:     out_load   = out_free;
            default:       ;
        endcase
    end

    assign sample.ready = in_ready;

    // ------------------------------------------------------------------
    // Window bookkeeping
    // ------------------------------------------------------------------
    assign wrap      = (pos_reg == POS_W'(WINDOW - 1));
    assign pos_next  = wrap ? '0 : pos_reg + 1'b1;
    assign fill_next = (fill_reg == CNT_W'(WINDOW)) ? fill_reg : fill_reg + 1'b1;
    assign edge_inc  = sample.motion && !last_motion_reg && (edge_cnt_reg != EDGE_MAX);
    assign edge_hit  = edge_cnt_reg + EDGE_W'(edge_inc);

    assign old_val    = old_valid_reg ? $signed(ram_rdata) : '0;
    assign sum_next   = sum_reg + SUM_W'(temp_reg) - SUM_W'(old_val);
    assign sumsq_next = sumsq_reg + SQ_W'(mul0_p) - SQ_W'(mul1_p);

    assign n_sumsq  = NUM_W'(mul0_p);
    assign sum_sq   = NUM_W'(mul1_p);
    assign num_next = (n_sumsq >= sum_sq) ? n_sumsq - sum_sq : '0;
    assign den      = DEN_W'(fill_reg) * DEN_W'(fill_reg - 1'b1);

    assign t_mag  = temp_reg[TEMP_W-1] ? (~temp_reg + 1'b1) : temp_reg;
    assign o_mag  = old_reg[TEMP_W-1] ? (~old_reg + 1'b1) : old_reg;
    assign s1_mag = sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            pos_reg          <= '0;
            fill_reg         <= '0;
            sum_reg          <= '0;
            sumsq_reg        <= '0;
            edge_cnt_reg     <= '0;
            last_motion_reg  <= 1'b0;
            window_start_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                pos_reg         <= pos_next;
                fill_reg        <= fill_next;
                last_motion_reg <= sample.motion;
                if (wrap)
                begin
                    edge_cnt_reg     <= '0;
                    window_start_reg <= sample.time_ms;
                end
                else
                begin
                    edge_cnt_reg <= edge_hit;
                end
            end
            if (load_item)
            begin
                sum_reg <= sum_next;
            end
            if (state_reg == ST_SQ_WAIT && !mul_busy)
            begin
                sumsq_reg <= sumsq_next;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            temp_reg      <= sample.temperature;
            hum_reg       <= sample.humidity;
            motion_reg    <= sample.motion;
            door_reg      <= sample.door_state;
            time_reg      <= sample.time_ms;
            item_pos_reg  <= pos_reg;
            old_valid_reg <= (CNT_W'(pos_reg) < fill_reg);
            elapsed_reg   <= sample.time_ms - window_start_reg;
            rate_num_reg  <= RATE_NUM_W'(edge_hit) * RATE_NUM_W'(MS_PER_S_Q8);
        end
        if (load_item)
        begin
            old_reg <= old_val;
        end
        if (state_reg == ST_PROD_WAIT && !mul_busy)
        begin
            num_reg <= num_next;
        end
        if (out_load)
        begin
            temp_out_reg   <= temp_reg;
            hum_out_reg    <= hum_reg;
            motion_out_reg <= motion_reg;
            door_out_reg   <= door_reg;
            mean_out_reg   <= mean_val;
            var_out_reg    <= var_val;
            rate_out_reg   <= rate_val;
            time_out_reg   <= time_reg;
        end
    end

    // ------------------------------------------------------------------
    // Temperature ring
    // ------------------------------------------------------------------
    rws_ram #(
        .WIDTH (TEMP_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (load_item),
        .waddr (item_pos_reg),
        .wdata (temp_reg),
        .raddr (pos_reg),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Multipliers: squares first, then n*S2 and S1*S1
    // ------------------------------------------------------------------
    assign mul_start = sq_start || prod_start;
    assign mul0_a    = sq_start ? MUL_A_W'(t_mag) : MUL_A_W'(sumsq_reg);
    assign mul0_b    = sq_start ? MUL_B_W'(t_mag) : MUL_B_W'(fill_reg);
    assign mul1_a    = sq_start ? MUL_A_W'(o_mag) : MUL_A_W'(s1_mag);
    assign mul1_b    = sq_start ? MUL_B_W'(o_mag) : MUL_B_W'(s1_mag);

    rws_mul u_mul0 (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul0_a),
        .b       (mul0_b),
        .busy    (mul0_busy),
        .product (mul0_p)
    );

    rws_mul u_mul1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul1_a),
        .b       (mul1_b),
        .busy    (mul1_busy),
        .product (mul1_p)
    );

    // ------------------------------------------------------------------
    // Dividers: rate, mean, variance
    // ------------------------------------------------------------------
    rws_div u_rate_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (load_item),
        .dividend (DIV_N_W'(rate_num_reg)),
        .divisor  (elapsed_reg),
        .busy     (rate_busy),
        .quotient (rate_q)
    );

    rws_div u_mean_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .dividend (DIV_N_W'(s1_mag)),
        .divisor  (DIV_D_W'(fill_reg)),
        .busy     (mean_busy),
        .quotient (mean_q)
    );

    rws_div u_var_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (var_start),
        .dividend (num_reg),
        .divisor  (DIV_D_W'(den)),
        .busy     (var_busy),
        .quotient (var_q)
    );

    // ------------------------------------------------------------------
    // Result formatting: sign, saturation, special cases
    // ------------------------------------------------------------------
    assign mean_mag = TEMP_W'(mean_q);
    assign mean_val = sum_reg[SUM_W-1] ? (~mean_mag + 1'b1) : mean_mag;

    always_comb
    begin
        priority if (fill_reg < CNT_W'(2))
        begin
            var_val = '0;
        end
        else if (|var_q[DIV_N_W-1:VAR_W])
        begin
            var_val = VAR_MAX;
        end
        else
        begin
            var_val = var_q[VAR_W-1:0];
        end
    end

    always_comb
    begin
        priority if (elapsed_reg == '0)
        begin
            rate_val = '0;
        end
        else if (|rate_q[DIV_N_W-1:RATE_W])
        begin
            rate_val = RATE_MAX;
        end
        else
        begin
            rate_val = rate_q[RATE_W-1:0];
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.temp_out     = temp_out_reg;
    assign result.humidity_out = hum_out_reg;
    assign result.motion_out   = motion_out_reg;
    assign result.door_out     = door_out_reg;
    assign result.temp_mean    = mean_out_reg;
    assign result.temp_var     = var_out_reg;
    assign result.motion_rate  = rate_out_reg;
    assign result.time_out     = time_out_reg;

`ifndef SYNTHESIS
    a_ring_order: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == CNT_W'(WINDOW)) || (CNT_W'(pos_reg) == fill_reg))
        else $error("write position out of step with fill count");

    a_units_started: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SQ_START |=> mul0_busy && mul1_busy && mean_busy)
        else $error("square pass did not start its units");

    a_side_divs_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_VAR_WAIT && !var_busy |-> !mean_busy && !rate_busy)
        else $error("mean or rate division still running at finish");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_FINISH)
        else $error("result word raised outside finish");
`endif

endmodule

// ===== design/rws_ram.sv =====
// ----------------------------------------------------------------------------
// rws_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rws_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/rws_mul.sv =====
// ----------------------------------------------------------------------------
// rws_mul: radix-2 shift-add multiplier
// Unsigned product, one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module rws_mul (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rws_pkg::MUL_A_W-1:0] a,
    input  logic [rws_pkg::MUL_B_W-1:0] b,
    output logic                        busy,
    output logic [rws_pkg::MUL_P_W-1:0] product
);
    import rws_pkg::*;

    logic [MUL_CNT_W-1:0] cnt_reg;
    logic [MUL_A_W-1:0]   mcand_reg;
    logic [MUL_P_W-1:0]   prod_reg;
    logic [MUL_A_W:0]     partial;

    // add the multiplicand into the upper half when the current bit is set
    assign partial = {1'b0, prod_reg[MUL_P_W-1:MUL_B_W]}
                   + (prod_reg[0] ? {1'b0, mcand_reg} : {(MUL_A_W + 1){1'b0}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= MUL_CNT_W'(MUL_B_W);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg <= a;
            prod_reg  <= {{MUL_A_W{1'b0}}, b};
        end
        else if (busy)
        begin
            prod_reg <= {partial, prod_reg[MUL_B_W-1:1]};
        end
    end

    assign busy    = (cnt_reg != '0);
    assign product = prod_reg;

endmodule

// ===== design/rws_div.sv =====
// ----------------------------------------------------------------------------
// rws_div: restoring divider
// Unsigned quotient, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module rws_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [rws_pkg::DIV_N_W-1:0] dividend,
    input  logic [rws_pkg::DIV_D_W-1:0] divisor,
    output logic                        busy,
    output logic [rws_pkg::DIV_N_W-1:0] quotient
);
    import rws_pkg::*;

    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_N_W-1:0]   quo_reg;
    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_D_W-1:0]   dvs_reg;
    logic [DIV_D_W:0]     trial;
    logic [DIV_D_W:0]     diff;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[DIV_N_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= DIV_CNT_W'(DIV_N_W);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy)
        begin
            quo_reg <= {quo_reg[DIV_N_W-2:0], fits};
            rem_reg <= fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
        end
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for rolling_window_stats
// Streams sensor readings through the block with random gaps and stalls on
// both channels, including long output hold-offs that back the block up.
// A scoreboard predicts every statistics word from its own window, sum and
// motion-edge state and checks each result field by field, in order.
// ----------------------------------------------------------------------------
module tb;
    import rws_pkg::*;

    localparam int RANDOM_READINGS = 1040;
    localparam int HOLD_CYCLES = 600;
    localparam int DRAIN_CYCLES = 150;

    typedef struct {
        logic signed [TEMP_W-1:0] temperature;
        logic [HUM_W-1:0]         humidity;
        logic                     motion;
        logic                     door_state;
        logic [TIME_W-1:0]        time_ms;
    } reading_t;

    typedef struct {
        logic signed [TEMP_W-1:0] temp_out;
        logic [HUM_W-1:0]         humidity_out;
        logic                     motion_out;
        logic                     door_out;
        logic signed [TEMP_W-1:0] temp_mean;
        logic [VAR_W-1:0]         temp_var;
        logic [RATE_W-1:0]        motion_rate;
        logic [TIME_W-1:0]        time_out;
    } stats_t;

    class stats_scoreboard;
        logic signed [TEMP_W-1:0] temp_ring[WINDOW];
        logic [POS_W-1:0]         ring_pos;
        int                       samples_held;
        longint                   temp_sum;
        longint                   temp_sum_sq;
        int                       edge_total;
        logic                     prev_motion;
        logic [TIME_W-1:0]        motion_start;
        stats_t                   expected_stats[$];
        int                       mismatches;

        function new();
            foreach (temp_ring[i])
                temp_ring[i] = '0;
            ring_pos = '0;
            samples_held = 0;
            temp_sum = 0;
            temp_sum_sq = 0;
            edge_total = 0;
            prev_motion = 1'b0;
            motion_start = '0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_stats.size();
        endfunction

        task report_mismatch(string what);
            $display("%0t mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        function void note_reading(reading_t r);
            stats_t            s;
            longint            t;
            longint            old_t;
            longint            n;
            longint            mean;
            longint            numer;
            longint unsigned   variance;
            longint unsigned   rate;
            logic [TIME_W-1:0] elapsed;
            logic              wrapped;

            t = r.temperature;
            old_t = temp_ring[ring_pos];
            temp_sum += t - old_t;
            temp_sum_sq += t * t - old_t * old_t;
            temp_ring[ring_pos] = r.temperature;
            ring_pos = ring_pos + 1'b1;
            wrapped = (ring_pos == '0);
            if (samples_held < WINDOW)
                samples_held++;

            n = samples_held;
            mean = temp_sum / n;
            variance = 0;
            if (samples_held >= 2)
            begin
                numer = n * temp_sum_sq - temp_sum * temp_sum;
                if (numer < 0)
                    numer = 0;
                variance = longint'(unsigned'(numer)) / (n * (n - 1));
                if (variance > VAR_MAX)
                    variance = VAR_MAX;
            end

            if (r.motion && !prev_motion && edge_total < EDGE_MAX)
                edge_total++;
            prev_motion = r.motion;

            elapsed = r.time_ms - motion_start;
            rate = 0;
            if (elapsed != '0)
            begin
                rate = (longint'(unsigned'(edge_total)) * MS_PER_S_Q8) / elapsed;
                if (rate > RATE_MAX)
                    rate = RATE_MAX;
            end

            if (wrapped)
            begin
                edge_total = 0;
                motion_start = r.time_ms;
            end

            s.temp_out = r.temperature;
            s.humidity_out = r.humidity;
            s.motion_out = r.motion;
            s.door_out = r.door_state;
            s.temp_mean = mean[TEMP_W-1:0];
            s.temp_var = variance[VAR_W-1:0];
            s.motion_rate = rate[RATE_W-1:0];
            s.time_out = r.time_ms;
            expected_stats.push_back(s);
        endfunction

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %h expected %h", name, got, want));
        endtask

        task check_result(stats_t got);
            stats_t want;
            if (expected_stats.size() == 0)
            begin
                report_mismatch("result word with nothing expected");
                return;
            end
            want = expected_stats.pop_front();
            compare_field("temp_out", got.temp_out, want.temp_out);
            compare_field("humidity_out", got.humidity_out, want.humidity_out);
            compare_field("motion_out", got.motion_out, want.motion_out);
            compare_field("door_out", got.door_out, want.door_out);
            compare_field("temp_mean", got.temp_mean, want.temp_mean);
            compare_field("temp_var", got.temp_var, want.temp_var);
            compare_field("motion_rate", got.motion_rate, want.motion_rate);
            compare_field("time_out", got.time_out, want.time_out);
        endtask
    endclass

    logic clk;
    logic rst_n;

    rws_sample_if sample_ch ();
    rws_result_if result_ch ();

    rolling_window_stats dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch)
    );

    stats_scoreboard sb = new();

    bit                       tx_steady;
    bit                       rx_steady;
    int                       hold_off_count;
    logic [TIME_W-1:0]        sensor_clock;
    logic signed [TEMP_W-1:0] temp_base;
    logic                     motion_level;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic reading_t make_reading(int temp, int hum, int mot, int door,
                                              logic [TIME_W-1:0] tm);
        reading_t r;
        r.temperature = temp[TEMP_W-1:0];
        r.humidity = hum[HUM_W-1:0];
        r.motion = mot[0];
        r.door_state = door[0];
        r.time_ms = tm;
        return r;
    endfunction

    task automatic send_reading(reading_t r);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            sample_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.temperature = r.temperature;
        sample_ch.humidity = r.humidity;
        sample_ch.motion = r.motion;
        sample_ch.door_state = r.door_state;
        sample_ch.time_ms = r.time_ms;
        sample_ch.valid = 1'b1;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        sb.note_reading(r);
        @(negedge clk);
    endtask

    task automatic random_reading(output reading_t r);
        int kind;
        int dt_kind;
        int offset;
        kind = $urandom_range(0, 99);
        if (kind < 10)
        begin
            r.temperature = TEMP_W'($urandom);
            r.humidity = HUM_W'($urandom);
            r.motion = 1'($urandom_range(0, 1));
            r.door_state = 1'($urandom_range(0, 1));
            r.time_ms = $urandom;
            sensor_clock = r.time_ms;
            return;
        end
        dt_kind = $urandom_range(0, 9);
        if (dt_kind == 9)
            sensor_clock += $urandom;
        else if (dt_kind != 0)
            sensor_clock += $urandom_range(1, 3000);
        if ($urandom_range(0, 29) == 0)
            temp_base = TEMP_W'($urandom);
        if (kind < 30)
            r.temperature = TEMP_W'($urandom);
        else
        begin
            offset = int'($urandom_range(0, 1024)) - 512;
            r.temperature = TEMP_W'(temp_base + offset);
        end
        if ($urandom_range(0, 3) == 0)
            motion_level = ~motion_level;
        r.motion = motion_level;
        r.humidity = HUM_W'($urandom);
        r.door_state = 1'($urandom_range(0, 1));
        r.time_ms = sensor_clock;
    endtask

    initial
    begin
        stats_t got;
        int     stall;
        int     taken;
        int     holds_done;
        result_ch.ready = 1'b0;
        rx_steady = 1'b0;
        taken = 0;
        holds_done = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_off_count > holds_done)
            begin
                result_ch.ready = 1'b0;
                holds_done++;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            stall = rx_steady ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                result_ch.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_ch.ready = 1'b1;
            do
                @(posedge clk);
            while (result_ch.valid !== 1'b1);
            got.temp_out = result_ch.temp_out;
            got.humidity_out = result_ch.humidity_out;
            got.motion_out = result_ch.motion_out;
            got.door_out = result_ch.door_out;
            got.temp_mean = result_ch.temp_mean;
            got.temp_var = result_ch.temp_var;
            got.motion_rate = result_ch.motion_rate;
            got.time_out = result_ch.time_out;
            sb.check_result(got);
            taken++;
            if (taken % 48 == 0)
                rx_steady = ($urandom_range(0, 3) == 0);
        end
    end

    initial
    begin
        reading_t r;
        rst_n = 1'b0;
        tx_steady = 1'b0;
        hold_off_count = 0;
        sensor_clock = '0;
        temp_base = '0;
        motion_level = 1'b0;
        sample_ch.valid = 1'b0;
        sample_ch.temperature = '0;
        sample_ch.humidity = '0;
        sample_ch.motion = 1'b0;
        sample_ch.door_state = 1'b0;
        sample_ch.time_ms = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_reading(make_reading(0, 0, 0, 0, 32'd0));
        send_reading(make_reading(32767, 16'hFFFF, 1, 1, 32'd0));
        send_reading(make_reading(-32768, 0, 0, 0, 32'd1));
        send_reading(make_reading(32767, 16'h5555, 1, 0, 32'd2));
        send_reading(make_reading(-32768, 16'hAAAA, 0, 1, 32'd3));
        send_reading(make_reading(-1, 1, 1, 1, 32'd1000));
        send_reading(make_reading(1, 16'h8000, 0, 0, 32'd2000));
        send_reading(make_reading(256, 16'h7FFF, 1, 0, 32'h7FFF_FFFF));
        send_reading(make_reading(-256, 2, 1, 1, 32'h8000_0000));
        send_reading(make_reading(0, 0, 0, 0, 32'hFFFF_FFF0));
        for (int k = 0; k < 6; k++)
            send_reading(make_reading(k[0] ? 32767 : -32768, 16'h1234 << k, k[0], !k[0],
                                      32'hFFFF_FFFA + k));
        send_reading(make_reading(100, 3, 0, 0, 32'hFFFF_FFFF));
        send_reading(make_reading(-100, 4, 1, 1, 32'd0));
        send_reading(make_reading(12800, 5, 0, 0, 32'd5));
        send_reading(make_reading(-12800, 6, 1, 1, 32'h0000_1000));

        sensor_clock = 32'h0000_1000;
        for (int i = 0; i < RANDOM_READINGS; i++)
        begin
            if (i % 50 == 0)
                tx_steady = ($urandom_range(0, 3) == 0);
            if (i == 300 || i == 700)
                hold_off_count++;
            random_reading(r);
            send_reading(r);
        end
        sample_ch.valid = 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("[rolling_window_stats] OK");
        else
            $display("[rolling_window_stats] ERROR");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("[rolling_window_stats] ERROR");
        $finish;
    end

endmodule
